@@ design/edit_distance_engine_defines.svh @@
// assertion macros used by the edit distance engine
`ifndef EDIT_DISTANCE_ENGINE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EDE_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("edit distance engine: check failed");

// next-cycle implication, disabled during reset
`define EDE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("edit distance engine: check failed");

`endif

@@ design/ede_pkg.sv @@
// shared types and constants of the edit distance engine
package ede_pkg;

  localparam int MAX_LEN_DEFAULT = 32;
  localparam int CH_W            = 8;
  localparam int DIST_W          = 6;
  localparam int DIST_MAX        = 63;

  localparam logic OP_FIRST  = 1'b0;
  localparam logic OP_SECOND = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic            arm;
    logic            load;
    logic [CH_W-1:0] ch;
  } cell_ctl_t;

endpackage

@@ design/ede_in_if.sv @@
// request channel: characters of the first and second word
interface ede_in_if;
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [ede_pkg::CH_W-1:0] ch;
  logic                   last;
  logic                   empty_req;

  modport source (output valid, op, ch, last, empty_req, input ready);
  modport sink   (input valid, op, ch, last, empty_req, output ready);
endinterface

@@ design/ede_out_if.sv @@
// result channel: edit distance and overflow flag
interface ede_out_if;
  logic                       valid;
  logic                       ready;
  logic [ede_pkg::DIST_W-1:0] distance;
  logic                       too_long;

  modport source (output valid, distance, too_long, input ready);
  modport sink   (input valid, distance, too_long, output ready);
endinterface

@@ design/edit_distance_engine.sv @@
// Levenshtein edit distance engine: a chain of MAX_LEN cells, one per
// first-word character, sweeps each second-word character through the kept
// column as a wavefront. Second-word characters are taken one per cycle
// while the engine runs and no first word is being closed. A first-word
// character waits until the chain is empty. The first second-word request
// after loading first closes the first word and is taken in the cycle after.
// A second-word end lets the wavefront drain through all MAX_LEN cells, and
// the result is then registered once the result channel has room; the next
// request is already held meanwhile. After reset the stored first word is
// empty and the column holds entry i = i.
`include "edit_distance_engine_defines.svh"

module edit_distance_engine #(
  parameter int MAX_LEN = ede_pkg::MAX_LEN_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  ede_in_if.sink   req,
  ede_out_if.source res
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SW = (LW > ede_pkg::DIST_W) ? LW : ede_pkg::DIST_W;

  ede_pkg::state_t state, state_next;

  // held request
  logic                     hold_valid;
  logic                     hold_op;
  logic [ede_pkg::CH_W-1:0] hold_ch;
  logic                     hold_last;
  logic                     hold_empty;

  logic          loading;
  logic          first_over;
  logic          overflow_seen;
  logic [LW-1:0] first_length;
  logic [LW-1:0] second_length;

  logic                      out_valid;
  logic [ede_pkg::DIST_W-1:0] out_distance;
  logic                      out_too_long;

  // chain links: index 0 is the injection point
  logic [MAX_LEN:0]         tok_valid;
  logic [ede_pkg::CH_W-1:0] tok_ch  [MAX_LEN+1];
  logic [LW-1:0]            tok_new [MAX_LEN+1];
  logic [LW-1:0]            tok_old [MAX_LEN+1];
  logic [LW-1:0]            cell_dp [MAX_LEN];
  ede_pkg::cell_ctl_t       cell_ctl [MAX_LEN];

  logic          busy;
  logic          hold_ends;
  logic          consume;
  logic          inject;
  logic          load_fire;
  logic          close_fire;
  logic          emit;
  logic          arm;
  logic [LW-1:0] fl_base;
  logic          fl_full;
  logic          sl_full;
  logic          store_ch;
  logic [IW-1:0] wr_idx;
  logic [LW-1:0] rd_pos;
  logic [IW-1:0] rd_idx;
  logic [LW-1:0] rd_dp;
  logic [SW-1:0] rd_ext;
  logic [ede_pkg::DIST_W-1:0] dist_sat;

  assign busy      = |tok_valid[MAX_LEN:1];
  assign hold_ends = hold_last | hold_empty;
  assign fl_base   = loading ? first_length : '0;
  assign fl_full   = (fl_base == LW'(MAX_LEN));
  assign sl_full   = (second_length == LW'(MAX_LEN));
  assign wr_idx    = fl_base[IW-1:0];

  // outputs of the sequencer
  always_comb begin
    consume    = 1'b0;
    inject     = 1'b0;
    load_fire  = 1'b0;
    close_fire = 1'b0;
    emit       = 1'b0;
    case (state)
      ede_pkg::ST_RUN: begin
        if (hold_valid) begin
          if (hold_op == ede_pkg::OP_FIRST) begin
            // store writes must not overtake a wavefront in flight
            if (!busy) begin
              load_fire = 1'b1;
              consume   = 1'b1;
            end
          end else if (loading) begin
            close_fire = 1'b1;
          end else begin
            consume = 1'b1;
            inject  = !hold_empty && !sl_full;
          end
        end
      end
      ede_pkg::ST_DRAIN: begin
      end
      ede_pkg::ST_EMIT: begin
        emit = !out_valid || res.ready;
      end
      default: begin
      end
    endcase
  end

  assign arm      = close_fire | (load_fire & hold_ends) | emit;
  assign store_ch = load_fire & !hold_empty & !fl_full;

  // next state of the sequencer
  always_comb begin
    state_next = state;
    case (state)
      ede_pkg::ST_RUN: begin
        if (consume && hold_op == ede_pkg::OP_SECOND && hold_ends) begin
          state_next = ede_pkg::ST_DRAIN;
        end
      end
      ede_pkg::ST_DRAIN: begin
        if (!busy) begin
          state_next = ede_pkg::ST_EMIT;
        end
      end
      ede_pkg::ST_EMIT: begin
        if (emit) begin
          state_next = ede_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = ede_pkg::ST_RUN;
      end
    endcase
  end

  assign req.ready = !hold_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ede_pkg::ST_RUN;
      hold_valid    <= 1'b0;
      loading       <= 1'b0;
      first_over    <= 1'b0;
      overflow_seen <= 1'b0;
      first_length  <= '0;
      second_length <= '0;
    end else begin
      state <= state_next;
      if (req.valid && req.ready) begin
        hold_valid <= 1'b1;
      end else if (consume) begin
        hold_valid <= 1'b0;
      end

      if (load_fire) begin
        loading <= !hold_ends;
        if (!loading || hold_ends) begin
          second_length <= '0;
        end
        if (!loading) begin
          first_over    <= 1'b0;
          overflow_seen <= 1'b0;
        end
        if (!hold_empty && fl_full) begin
          first_over    <= 1'b1;
          overflow_seen <= 1'b1;
        end
        first_length <= fl_base + LW'(store_ch);
      end

      if (close_fire) begin
        loading       <= 1'b0;
        second_length <= '0;
      end

      if (consume && hold_op == ede_pkg::OP_SECOND && !hold_empty && sl_full) begin
        overflow_seen <= 1'b1;
      end

      if (inject) begin
        second_length <= second_length + LW'(1);
      end

      if (emit) begin
        second_length <= '0;
        overflow_seen <= first_over;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      hold_op    <= req.op;
      hold_ch    <= req.ch;
      hold_last  <= req.last;
      hold_empty <= req.empty_req;
    end
  end

  // injection into the first cell: left column entry is the second length
  assign tok_valid[0] = inject;
  assign tok_ch[0]    = hold_ch;
  assign tok_old[0]   = second_length;
  assign tok_new[0]   = second_length + LW'(1);

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    assign cell_ctl[i].arm  = arm;
    assign cell_ctl[i].load = store_ch && (wr_idx == IW'(i));
    assign cell_ctl[i].ch   = hold_ch;

    ede_cell #(
      .DW  (LW),
      .IDX (i + 1)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl[i]),
      .in_valid  (tok_valid[i]),
      .in_ch     (tok_ch[i]),
      .in_new    (tok_new[i]),
      .in_old    (tok_old[i]),
      .out_valid (tok_valid[i+1]),
      .out_ch    (tok_ch[i+1]),
      .out_new   (tok_new[i+1]),
      .out_old   (tok_old[i+1]),
      .dp        (cell_dp[i])
    );
  end

  // column entry at the first word's length
  always_comb begin
    rd_pos = first_length - LW'(1);
    rd_idx = rd_pos[IW-1:0];
    rd_dp  = (first_length == '0) ? second_length : cell_dp[rd_idx];
    rd_ext = SW'(rd_dp);
    dist_sat = (rd_ext > SW'(ede_pkg::DIST_MAX)) ?
               ede_pkg::DIST_W'(ede_pkg::DIST_MAX) : rd_ext[ede_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_distance <= dist_sat;
      out_too_long <= overflow_seen;
    end
  end

  assign res.valid    = out_valid;
  assign res.distance = out_distance;
  assign res.too_long = out_too_long;

  `EDE_ASSERT_IMPL(a_inject_in_run, clk, rst, inject, state == ede_pkg::ST_RUN)
  `EDE_ASSERT_IMPL(a_load_when_idle, clk, rst, load_fire, !busy && !inject)
  `EDE_ASSERT_NEXT(a_drain_waits, clk, rst, state == ede_pkg::ST_DRAIN && busy, state == ede_pkg::ST_DRAIN)
  `EDE_ASSERT_NEXT(a_emit_shows, clk, rst, emit, out_valid)
  `EDE_ASSERT_IMPL(a_len_bound, clk, rst, 1'b1, second_length <= LW'(MAX_LEN) && first_length <= LW'(MAX_LEN))

endmodule

@@ design/ede_cell.sv @@
// one column cell: holds a first-word character and its distance entry
module ede_cell #(
  parameter int DW  = 6,
  parameter int IDX = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ede_pkg::cell_ctl_t        ctl,
  input  logic                      in_valid,
  input  logic [ede_pkg::CH_W-1:0]  in_ch,
  input  logic [DW-1:0]             in_new,
  input  logic [DW-1:0]             in_old,
  output logic                      out_valid,
  output logic [ede_pkg::CH_W-1:0]  out_ch,
  output logic [DW-1:0]             out_new,
  output logic [DW-1:0]             out_old,
  output logic [DW-1:0]             dp
);

  logic [ede_pkg::CH_W-1:0] stored;
  logic [DW:0]              up_cost;
  logic [DW:0]              left_cost;
  logic [DW:0]              diag_cost;
  logic [DW:0]              min_ul;
  logic [DW:0]              min_all;
  logic [DW-1:0]            dp_new;

  always_comb begin
    up_cost   = {1'b0, dp} + {{DW{1'b0}}, 1'b1};
    left_cost = {1'b0, in_new} + {{DW{1'b0}}, 1'b1};
    diag_cost = {1'b0, in_old} + {{DW{1'b0}}, (in_ch != stored)};
    min_ul    = (up_cost < left_cost) ? up_cost : left_cost;
    min_all   = (min_ul < diag_cost) ? min_ul : diag_cost;
    // never exceeds the larger word length, so it fits in DW bits
    dp_new    = min_all[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dp        <= DW'(IDX);
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
      if (ctl.arm) begin
        dp <= DW'(IDX);
      end else if (in_valid) begin
        dp <= dp_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      stored <= ctl.ch;
    end
    out_ch  <= in_ch;
    out_new <= dp_new;
    out_old <= dp;
  end

endmodule

@@ bench/ede_tb_pkg.sv @@
// scoreboard for the edit distance engine: tracks the word pair and the pending distances
package ede_tb_pkg;
  import ede_pkg::*;

  localparam int WORD_MAX = MAX_LEN_DEFAULT;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } distance_t;

  class distance_scoreboard;
    logic [CH_W-1:0] first_chars [WORD_MAX];
    int              first_len;
    int              second_len;
    int              column [WORD_MAX+1];
    bit              over_seen;
    bit              first_over;
    bit              loading;
    distance_t       pending_distances [$];
    int              requests;
    int              checked;
    int              mismatches;

    function new();
      foreach (first_chars[i]) first_chars[i] = '0;
      first_len  = 0;
      over_seen  = 0;
      first_over = 0;
      loading    = 0;
      requests   = 0;
      checked    = 0;
      mismatches = 0;
      rearm_column();
    endfunction

    function void rearm_column();
      for (int i = 0; i <= WORD_MAX; i++) column[i] = i;
      second_len = 0;
    endfunction

    function int outstanding();
      return pending_distances.size();
    endfunction

    // advance the kept column by one accepted request
    function void note_request(logic op, logic [CH_W-1:0] ch, logic last, logic empty_req);
      bit        ends;
      int        diag;
      int        above;
      int        best;
      int        cost;
      int        d;
      distance_t want;
      ends = last || empty_req;
      requests++;
      if (op == OP_FIRST) begin
        if (!loading) begin
          first_len  = 0;
          second_len = 0;
          over_seen  = 0;
          first_over = 0;
          loading    = 1;
        end
        if (!empty_req) begin
          if (first_len < WORD_MAX) begin
            first_chars[first_len] = ch;
            first_len++;
          end else begin
            first_over = 1;
            over_seen  = 1;
          end
        end
        if (ends) begin
          loading = 0;
          rearm_column();
        end
        return;
      end
      // a second-word request closes an open first word
      if (loading) begin
        loading = 0;
        rearm_column();
      end
      if (!empty_req) begin
        if (second_len < WORD_MAX) begin
          diag = column[0];
          second_len++;
          column[0] = second_len;
          for (int i = 1; i <= first_len; i++) begin
            above = column[i];
            cost  = (first_chars[i-1] == ch) ? 0 : 1;
            best  = above + 1;
            if (column[i-1] + 1 < best) best = column[i-1] + 1;
            if (diag + cost < best) best = diag + cost;
            column[i] = best;
            diag = above;
          end
        end else begin
          over_seen = 1;
        end
      end
      if (!ends) return;
      d = column[first_len];
      if (d > DIST_MAX) d = DIST_MAX;
      want.distance = d[DIST_W-1:0];
      want.too_long = over_seen;
      pending_distances = {pending_distances, want};
      rearm_column();
      over_seen = first_over;
    endfunction

    function void check_result(logic [DIST_W-1:0] distance, logic too_long);
      distance_t want;
      checked++;
      if (pending_distances.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: distance %0d too_long %0b", distance, too_long);
        return;
      end
      want = pending_distances.pop_front();
      if (distance !== want.distance || too_long !== want.too_long) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: distance exp %0d got %0d, too_long exp %0b got %0b",
                   checked, want.distance, distance, want.too_long, too_long);
      end
    endfunction
  endclass

endpackage

@@ bench/testbench.sv @@
// top-level testbench of the edit distance engine: stimulus, receiver and result checking
module testbench;
  import ede_pkg::*;
  import ede_tb_pkg::*;

  logic clk;
  logic rst;

  ede_in_if  req_if ();
  ede_out_if res_if ();

  edit_distance_engine u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .res (res_if)
  );

  distance_scoreboard sb;

  int send_idle;
  int recv_idle;
  bit hold_wanted;
  bit hold_done;
  int hold_left;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    res_if.ready = 1'b0;
    hold_done    = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_done) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      sb.check_result(res_if.distance, res_if.too_long);
  end

  task automatic send_req(logic op, logic [CH_W-1:0] ch, logic last, logic empty_req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.op        <= op;
    req_if.ch        <= ch;
    req_if.last      <= last;
    req_if.empty_req <= empty_req;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(op, ch, last, empty_req);
  endtask

  function automatic logic [CH_W-1:0] rand_char(int alpha);
    if (alpha >= 256) return CH_W'($urandom_range(255));
    return CH_W'(8'h61 + $urandom_range(alpha - 1));
  endfunction

  // mostly short words, a few at the limit and past it
  function automatic int rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 80) return $urandom_range(8, 1);
    if (r < 92) return $urandom_range(20, 9);
    if (r < 97) return $urandom_range(WORD_MAX, 21);
    return $urandom_range(WORD_MAX + 8, WORD_MAX + 1);
  endfunction

  // end_mode 0: last on final char, 1: trailing empty request, 2: left open
  task automatic send_word(logic op, int len, int alpha, int end_mode);
    if (len == 0) begin
      send_req(op, rand_char(256), 1'($urandom_range(1)), 1'b1);
      return;
    end
    for (int k = 0; k < len; k++)
      send_req(op, rand_char(alpha), (end_mode == 0 && k == len - 1), 1'b0);
    if (end_mode == 1)
      send_req(op, rand_char(256), 1'($urandom_range(1)), 1'b1);
  endtask

  initial begin
    int  r;
    int  alpha;
    int  target;
    int  fmode;
    bit  have_first;
    sb = new();
    req_if.valid     = 1'b0;
    req_if.op        = OP_FIRST;
    req_if.ch        = '0;
    req_if.last      = 1'b0;
    req_if.empty_req = 1'b0;
    send_idle   = 13;
    recv_idle   = 83;
    hold_wanted = 0;
    have_first  = 0;
    alpha       = 4;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty stored word after reset
    send_req(OP_SECOND, 8'hff, 1'b1, 1'b1);
    send_req(OP_SECOND, 8'h00, 1'b1, 1'b0);
    // extreme bytes, swapped and matching
    send_req(OP_FIRST, 8'h00, 1'b0, 1'b0);
    send_req(OP_FIRST, 8'hff, 1'b1, 1'b0);
    send_req(OP_SECOND, 8'hff, 1'b0, 1'b0);
    send_req(OP_SECOND, 8'h00, 1'b1, 1'b0);
    send_req(OP_SECOND, 8'h00, 1'b0, 1'b0);
    send_req(OP_SECOND, 8'hff, 1'b1, 1'b0);
    // empty first word
    send_req(OP_FIRST, 8'haa, 1'b1, 1'b1);
    send_req(OP_SECOND, 8'h55, 1'b1, 1'b0);
    // first word left open, closed by the second word
    send_req(OP_FIRST, 8'h0f, 1'b0, 1'b0);
    send_req(OP_FIRST, 8'hf0, 1'b0, 1'b0);
    send_req(OP_SECOND, 8'hf0, 1'b1, 1'b0);
    // first word ended by an empty request, then an empty second word
    send_req(OP_FIRST, 8'h12, 1'b0, 1'b0);
    send_req(OP_FIRST, 8'h34, 1'b0, 1'b1);
    send_req(OP_SECOND, 8'h00, 1'b0, 1'b1);
    // second word ended by an empty request after characters
    send_req(OP_SECOND, 8'h12, 1'b0, 1'b0);
    send_req(OP_SECOND, 8'h99, 1'b0, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 13;
          recv_idle = 83;
        end
        1: begin
          send_idle = 83;
          recv_idle = 13;
        end
        default: begin
          send_idle   = 0;
          recv_idle   = 0;
          hold_wanted = 1;
        end
      endcase
      target = sb.requests + 580;
      while (sb.requests < target) begin
        r = $urandom_range(99);
        if (r < 10) begin
          send_req(1'($urandom_range(1)), rand_char(256), 1'($urandom_range(1)),
                   ($urandom_range(3) == 0));
        end else if (r < 35 || !have_first) begin
          case ($urandom_range(3))
            0: alpha = 2;
            1: alpha = 4;
            2: alpha = 26;
            default: alpha = 256;
          endcase
          fmode = $urandom_range(9);
          fmode = (fmode < 6) ? 0 : (fmode < 8) ? 1 : 2;
          send_word(OP_FIRST, rand_len(), alpha, fmode);
          have_first = 1;
          repeat ($urandom_range(3, 1))
            send_word(OP_SECOND, rand_len(), alpha, ($urandom_range(3) == 0) ? 1 : 0);
        end else begin
          send_word(OP_SECOND, rand_len(), alpha, 0);
        end
      end
    end
    // one last second word so the stream ends on a result
    send_word(OP_SECOND, 3, alpha, 0);
    @(negedge clk);
    req_if.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (3 * WORD_MAX) @(posedge clk);

    $display("edit distance run: %0d requests, %0d distances checked, %0d mismatches",
             sb.requests, sb.checked, sb.mismatches);
    $display("covered empty and overflowing words, open first words and a long result stall");
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
